[rtl/fdlh_pkg.sv]
// ----------------------------------------------------------------------------
// fdlh_pkg
// Shared types and constants of the hermite fractional delay line.
// ----------------------------------------------------------------------------
package fdlh_pkg;

	localparam int LINE_DEPTH  = 4096;
	localparam int ADDR_W      = $clog2(LINE_DEPTH);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int DELAY_W     = 12;
	localparam int CFG_W       = 12;
	localparam int ACC_W       = 32;
	localparam int PROD_W      = ACC_W + FRAC_BITS + 1;
	localparam int SUM_W       = PROD_W + 2;
	localparam int RK_W        = $clog2(ADDR_W);

	localparam logic [CFG_W-1:0] MAX_DELAY_RESET = CFG_W'(4094);

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} command_t;

	typedef struct packed {
		logic                          command;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic [DELAY_W-1:0]            delay_whole;
		logic [FRAC_BITS-1:0]          delay_frac;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value_out;
		logic                          delay_clamped;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic red_start;
		logic red_step;
		logic wr_sample;
		logic rd_start;
		logic addr_step;
		logic cap_a;
		logic cap_b;
		logic cap_c;
		logic cap_d;
		logic diff;
		logic mul1;
		logic rnd1;
		logic mul2;
		logic rnd2;
		logic mul3;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic red_last;
	} ctl_sts_t;

	function automatic logic signed [ACC_W-1:0] sext_smp(input logic [SAMPLE_BITS-1:0] x);
		return {{(ACC_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
	endfunction

endpackage

[rtl/fdlh_ram.sv]
// ----------------------------------------------------------------------------
// fdlh_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module fdlh_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/fdlh_datapath.sv]
// ----------------------------------------------------------------------------
// fdlh_datapath
// Line store, pointers, tap addressing and the fixed point hermite evaluation.
// ----------------------------------------------------------------------------
module fdlh_datapath
	import fdlh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_cmd_t         cmd,
	output ctl_sts_t         sts,
	input  item_t            item,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output result_t          result
);

	localparam logic [CFG_W-1:0] MD_MAX = CFG_W'(LINE_DEPTH - 2);
	localparam logic signed [SUM_W-1:0] HALF1 = SUM_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] HALF2 = SUM_W'(1) <<< FRAC_BITS;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	logic [CFG_W-1:0]  max_delay_q;
	logic [ADDR_W-1:0] wp_q;
	logic [ADDR_W-1:0] p_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] rem_q;
	logic [RK_W-1:0]   k_q;
	logic [ADDR_W-1:0] idx_q;
	logic [FRAC_BITS-1:0] t_q;
	logic              clamp_q;

	logic [SAMPLE_BITS-1:0] ta_q, tb_q, tc_q, td_q;
	logic signed [ACC_W-1:0] coef_a_q, coef_b_q, s0_q, st_q;
	logic signed [PROD_W-1:0] prod_q;
	result_t res_q;

	logic [CFG_W-1:0] md_eff;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] len_m1;
	logic [LEN_W-1:0] wp_inc;
	logic [ADDR_W-1:0] wp_next;

	logic [LEN_W+ADDR_W-1:0] red_sub;
	logic [ADDR_W-1:0] rem_next;

	logic [LEN_W-1:0] d_in;
	logic             over;
	logic [LEN_W-1:0] d_eff;
	logic signed [LEN_W+1:0] x0, x1, x2;

	logic we;
	logic [ADDR_W-1:0] waddr;
	logic [SAMPLE_BITS-1:0] wdata;
	logic [SAMPLE_BITS-1:0] rdata;

	logic signed [ACC_W-1:0] ea, eb, ec, ed, s0, s1, vv, ww, ca, cb;
	logic signed [FRAC_BITS:0] tt;
	logic signed [SUM_W-1:0] sum1, sum2, sum3, y;

	// effective line length
	always_comb begin
		if (max_delay_q == '0) begin
			md_eff = CFG_W'(1);
		end else if (max_delay_q > MD_MAX) begin
			md_eff = MD_MAX;
		end else begin
			md_eff = max_delay_q;
		end
		len    = LEN_W'(md_eff) + LEN_W'(2);
		len_m1 = len - LEN_W'(1);
		wp_inc = LEN_W'(wp_q) + LEN_W'(1);
		wp_next = (wp_inc >= len) ? '0 : wp_inc[ADDR_W-1:0];
	end

	// one restoring remainder step per cycle
	always_comb begin
		red_sub = (LEN_W+ADDR_W)'(len) << k_q;
		if ((LEN_W+ADDR_W)'(rem_q) >= red_sub) begin
			rem_next = rem_q - red_sub[ADDR_W-1:0];
		end else begin
			rem_next = rem_q;
		end
	end

	// delay clamp and newest tap index
	always_comb begin
		d_in  = LEN_W'(item.delay_whole);
		over  = (d_in > len_m1) || ((d_in == len_m1) && (item.delay_frac != '0));
		d_eff = over ? len_m1 : d_in;
		x0 = signed'((LEN_W+2)'(p_q)) + (LEN_W+2)'(1) - signed'((LEN_W+2)'(d_eff));
		x1 = (x0 < 0) ? x0 + signed'((LEN_W+2)'(len)) : x0;
		x2 = (x1 >= signed'((LEN_W+2)'(len))) ? x1 - signed'((LEN_W+2)'(len)) : x1;
	end

	assign we    = cmd.clr_step | cmd.wr_sample;
	assign waddr = cmd.clr_step ? cnt_q : wp_next;
	assign wdata = cmd.clr_step ? '0 : item.sample_in;

	fdlh_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(LINE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q),
		.rdata(rdata)
	);

	// slope terms, all at twice the sample scale
	always_comb begin
		ea = sext_smp(ta_q);
		eb = sext_smp(tb_q);
		ec = sext_smp(tc_q);
		ed = sext_smp(td_q);
		s0 = ec - ea;
		s1 = ed - eb;
		vv = (eb - ec) <<< 1;
		ww = s0 + vv;
		ca = ww + vv + s1;
		cb = ww + ca;
		tt = signed'({1'b0, t_q});
	end

	// round half up is an arithmetic shift after adding half
	always_comb begin
		sum1 = SUM_W'(prod_q) - (SUM_W'(coef_b_q) <<< FRAC_BITS) + HALF1;
		sum2 = SUM_W'(prod_q) + (SUM_W'(s0_q) <<< FRAC_BITS) + HALF1;
		sum3 = SUM_W'(prod_q) + (SUM_W'(sext_smp(tb_q)) <<< (FRAC_BITS + 1)) + HALF2;
		y    = sum3 >>> (FRAC_BITS + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delay_q <= MAX_DELAY_RESET;
			wp_q        <= ADDR_W'(MAX_DELAY_RESET + CFG_W'(1));
			p_q         <= ADDR_W'(MAX_DELAY_RESET + CFG_W'(1));
			cnt_q       <= '0;
			k_q         <= '0;
		end else begin
			if (cfg_we) begin
				max_delay_q <= cfg_wdata;
			end
			if (cmd.clr_step) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			if (cmd.wr_sample) begin
				wp_q <= wp_next;
				p_q  <= wp_next;
			end
			if (cmd.red_start) begin
				k_q <= RK_W'(ADDR_W - 1);
			end else if (cmd.red_step) begin
				k_q <= k_q - RK_W'(1);
				if (k_q == '0) begin
					p_q <= rem_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.red_start) begin
			rem_q <= wp_q;
		end else if (cmd.red_step) begin
			rem_q <= rem_next;
		end
		if (cmd.rd_start) begin
			idx_q   <= x2[ADDR_W-1:0];
			t_q     <= over ? '0 : item.delay_frac;
			clamp_q <= over;
		end else if (cmd.addr_step) begin
			idx_q <= (idx_q == '0) ? len_m1[ADDR_W-1:0] : idx_q - ADDR_W'(1);
		end
		if (cmd.cap_a) ta_q <= rdata;
		if (cmd.cap_b) tb_q <= rdata;
		if (cmd.cap_c) tc_q <= rdata;
		if (cmd.cap_d) td_q <= rdata;
		if (cmd.diff) begin
			coef_a_q <= ca;
			coef_b_q <= cb;
			s0_q     <= s0;
		end
		if (cmd.mul1) begin
			prod_q <= coef_a_q * tt;
		end else if (cmd.mul2 || cmd.mul3) begin
			prod_q <= st_q * tt;
		end
		if (cmd.rnd1) begin
			st_q <= ACC_W'(sum1 >>> FRAC_BITS);
		end else if (cmd.rnd2) begin
			st_q <= ACC_W'(sum2 >>> FRAC_BITS);
		end
		if (cmd.load_out) begin
			if (y > SAT_HI) begin
				res_q.value_out <= SAT_HI[SAMPLE_BITS-1:0];
			end else if (y < SAT_LO) begin
				res_q.value_out <= SAT_LO[SAMPLE_BITS-1:0];
			end else begin
				res_q.value_out <= y[SAMPLE_BITS-1:0];
			end
			res_q.delay_clamped <= clamp_q;
		end
	end

	assign sts.clr_last = &cnt_q;
	assign sts.red_last = (k_q == '0);
	assign result       = res_q;

endmodule

[rtl/fdlh_ctrl.sv]
// ----------------------------------------------------------------------------
// fdlh_ctrl
// Sequencer: store clearing, pointer reduction, tap fetch and evaluation steps.
// ----------------------------------------------------------------------------
module fdlh_ctrl
	import fdlh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     item_command,
	input  logic     cfg_we,
	input  logic     result_stall,
	output logic     item_stall,
	output logic     result_valid,
	output ctl_cmd_t cmd,
	input  ctl_sts_t sts
);

	typedef enum logic [14:0] {
		ST_CLEAR  = 15'b000000000000001,
		ST_REDUCE = 15'b000000000000010,
		ST_IDLE   = 15'b000000000000100,
		ST_TAPA   = 15'b000000000001000,
		ST_TAPB   = 15'b000000000010000,
		ST_TAPC   = 15'b000000000100000,
		ST_TAPD   = 15'b000000001000000,
		ST_TAPE   = 15'b000000010000000,
		ST_DIFF   = 15'b000000100000000,
		ST_MUL1   = 15'b000001000000000,
		ST_RND1   = 15'b000010000000000,
		ST_MUL2   = 15'b000100000000000,
		ST_RND2   = 15'b001000000000000,
		ST_MUL3   = 15'b010000000000000,
		ST_OUT    = 15'b100000000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   pending_q;
	logic   valid_q;
	logic   accept;

	assign item_stall = (state_q != ST_IDLE) || pending_q;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_REDUCE: begin
				cmd.red_step = 1'b1;
				if (sts.red_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (pending_q) begin
					cmd.red_start = 1'b1;
					state_nxt     = ST_REDUCE;
				end else if (accept) begin
					if (item_command == CMD_READ) begin
						cmd.rd_start = 1'b1;
						state_nxt    = ST_TAPA;
					end else begin
						cmd.wr_sample = 1'b1;
					end
				end
			end
			ST_TAPA: begin
				cmd.addr_step = 1'b1;
				state_nxt     = ST_TAPB;
			end
			ST_TAPB: begin
				cmd.cap_a     = 1'b1;
				cmd.addr_step = 1'b1;
				state_nxt     = ST_TAPC;
			end
			ST_TAPC: begin
				cmd.cap_b     = 1'b1;
				cmd.addr_step = 1'b1;
				state_nxt     = ST_TAPD;
			end
			ST_TAPD: begin
				cmd.cap_c = 1'b1;
				state_nxt = ST_TAPE;
			end
			ST_TAPE: begin
				cmd.cap_d = 1'b1;
				state_nxt = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff  = 1'b1;
				state_nxt = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1  = 1'b1;
				state_nxt = ST_RND1;
			end
			ST_RND1: begin
				cmd.rnd1  = 1'b1;
				state_nxt = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = ST_RND2;
			end
			ST_RND2: begin
				cmd.rnd2  = 1'b1;
				state_nxt = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul3  = 1'b1;
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to be free
				if (!valid_q || !result_stall) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			pending_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// a new length needs the read pointer brought back into range
			if (cfg_we) begin
				pending_q <= 1'b1;
			end else if (cmd.red_start) begin
				pending_q <= 1'b0;
			end
			if (cmd.load_out) begin
				valid_q <= 1'b1;
			end else if (valid_q && !result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;

endmodule

[rtl/fractional_delay_line_hermite.sv]
// ----------------------------------------------------------------------------
// fractional_delay_line_hermite
// Circular audio delay line with four-tap cubic hermite fractional read.
//
//   channel   signals                                   transfer when
//   item      item_valid, item_stall, item             valid & !stall
//   result    result_valid, result_stall, result       valid & !stall
//   config    cfg_we, cfg_wdata (max_delay)            cfg_we
//
// A write is stored as it is taken; a read result is formed by four sequential
// tap reads through the single read port of the store and three chained
// multiply and round steps. After reset the whole store is cleared one entry
// a cycle, with item_stall high. A config write stalls the item channel while
// the read pointer is reduced against the new length.
// A held result does not block the next transfer in; only its load waits.
// ----------------------------------------------------------------------------
module fractional_delay_line_hermite
	import fdlh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	fdlh_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.result   (result)
	);

	fdlh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_command(item.command),
		.cfg_we      (cfg_we),
		.result_stall(result_stall),
		.item_stall  (item_stall),
		.result_valid(result_valid),
		.cmd         (cmd),
		.sts         (sts)
	);

	// clearing sweep and sample writes never share the store port
	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_step && cmd.wr_sample))
		else $error("clear and sample write together");

	// a held result is never overwritten
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(result_valid && result_stall))
		else $error("result overwritten while held");

	// a read transfer makes the block busy on the next cycle
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.command) |=> item_stall)
		else $error("input open during read evaluation");

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> item_stall)
		else $error("transfer taken during clearing");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hermite fractional delay line: a clocked driver
// feeds item transfers from a backlog, a clocked monitor predicts every
// interpolated read from its own copy of the line and checks each result
// transfer in order, across several max_delay settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;
	import fdlh_pkg::*;

	localparam int SMP_MAX   = 8388607;
	localparam int SMP_MIN   = -8388608;
	localparam int HOLD_LONG = 300;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	item_t            item_data    = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result_data;
	logic             cfg_we       = 1'b0;
	logic [CFG_W-1:0] cfg_wdata    = '0;

	// predictor state
	logic signed [SAMPLE_BITS-1:0] line_store [LINE_DEPTH];
	int                            line_wptr;
	logic [CFG_W-1:0]              line_max_delay;

	item_t   item_backlog [$];
	result_t interp_due [$];

	logic item_took = 1'b0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_req  = 0;
	int   hold_ack  = 0;
	int   hold_left = 0;

	int mismatch_count = 0;
	int writes_seen    = 0;
	int reads_seen     = 0;
	int clamps_seen    = 0;
	int settings_seen  = 0;

	fractional_delay_line_hermite u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	// line length actually used for a given register value
	function automatic int span_of(logic [CFG_W-1:0] md);
		int m;
		m = int'(md);
		if (m < 1) m = 1;
		if (m > LINE_DEPTH - 2) m = LINE_DEPTH - 2;
		return m + 2;
	endfunction

	// divide by 2^sh, rounding half towards plus infinity
	function automatic longint round_up_shift(longint x, int sh);
		return (x + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic void delay_line_apply(item_t it);
		int      len, p, base, d;
		longint  t, ta, tb_s, tc, td, s0, s1, v, w, a, b, st1, st2, y, unity;
		logic    clamp;
		result_t r;
		len   = span_of(line_max_delay);
		unity = longint'(1) <<< FRAC_BITS;
		if (it.command == CMD_WRITE) begin
			p = line_wptr + 1;
			if (p >= len) p = 0;
			line_wptr = p;
			line_store[p] = it.sample_in;
			writes_seen++;
		end else begin
			d = int'(it.delay_whole);
			t = longint'(it.delay_frac);
			clamp = 1'b0;
			if (d > len - 1 || (d == len - 1 && t != 0)) begin
				d = len - 1;
				t = 0;
				clamp = 1'b1;
			end
			// pointer may sit past the end after a length change
			p    = line_wptr % len;
			base = p + len + 1 - d;
			ta   = line_store[base % len];
			tb_s = line_store[(base + len - 1) % len];
			tc   = line_store[(base + len - 2) % len];
			td   = line_store[(base + len - 3) % len];
			s0   = tc - ta;
			s1   = td - tb_s;
			v    = 2 * (tb_s - tc);
			w    = s0 + v;
			a    = w + v + s1;
			b    = w + a;
			st1  = round_up_shift(a * t - b * unity, FRAC_BITS);
			st2  = round_up_shift(st1 * t + s0 * unity, FRAC_BITS);
			y    = round_up_shift(st2 * t + 2 * tb_s * unity, FRAC_BITS + 1);
			if (y > SMP_MAX) y = SMP_MAX;
			if (y < SMP_MIN) y = SMP_MIN;
			r.value_out     = SAMPLE_BITS'(y);
			r.delay_clamped = clamp;
			interp_due.push_back(r);
			reads_seen++;
			if (clamp) clamps_seen++;
		end
	endfunction

	function automatic item_t make_item(logic cmd, int smp, int dw, int df);
		item_t it;
		it.command     = cmd;
		it.sample_in   = SAMPLE_BITS'(smp);
		it.delay_whole = DELAY_W'(dw);
		it.delay_frac  = FRAC_BITS'(df);
		return it;
	endfunction

	// delays lean towards the recent past, with some at and beyond the end
	function automatic item_t random_item(int len);
		int smp, dw, df, sel;
		sel = $urandom_range(9);
		smp = (sel == 0) ? SMP_MAX : (sel == 1) ? SMP_MIN : int'($urandom);
		sel = $urandom_range(99);
		if (sel < 50) dw = $urandom_range((len - 1 < 40) ? len - 1 : 40, 0);
		else if (sel < 75) dw = $urandom_range(len - 1, 0);
		else if (sel < 85) dw = len - 1;
		else dw = $urandom_range(4095);
		sel = $urandom_range(9);
		df = (sel == 0) ? 0 : (sel == 1) ? 16'hFFFF : int'($urandom);
		return make_item($urandom_range(1) ? CMD_READ : CMD_WRITE, smp, dw, df);
	endfunction

	// driver: a payload stays until its transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_took) begin
			if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_data  <= item_backlog.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with an occasional long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack     <= hold_req;
			hold_left    <= HOLD_LONG;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: check result transfers, then predict from item transfers
	always @(posedge clk) begin
		result_t due;
		if (arst_n) begin
			item_took <= item_valid && !item_stall;
			if (result_valid && !result_stall) begin
				if (interp_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: value %0d clamped %0b",
							result_data.value_out, result_data.delay_clamped);
				end else begin
					due = interp_due.pop_front();
					if (result_data.value_out !== due.value_out ||
							result_data.delay_clamped !== due.delay_clamped) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected value %0d clamped %0b, got value %0d clamped %0b",
								due.value_out, due.delay_clamped,
								result_data.value_out, result_data.delay_clamped);
					end
				end
			end
			if (item_valid && !item_stall)
				delay_line_apply(item_data);
			if (cfg_we)
				line_max_delay = cfg_wdata;
		end
	end

	task automatic wait_results_done();
		while (!(item_backlog.size() == 0 && !item_valid && interp_due.size() == 0))
			@(posedge clk);
	endtask

	task automatic write_max_delay(int md);
		wait_results_done();
		// a trailing write transfer may still be in the block
		repeat (16) @(posedge clk);
		@(negedge clk);
		cfg_wdata <= CFG_W'(md);
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		settings_seen++;
	endtask

	task automatic queue_random(int n, int md);
		@(posedge clk);
		repeat (n) item_backlog.push_back(random_item(span_of(CFG_W'(md))));
	endtask

	initial begin
		int md_plan [9];
		int md;
		md_plan = '{4094, 1, 0, 7, 4095, 100, 0, 2, 0};
		md_plan[6] = $urandom_range(4093, 2);
		md_plan[8] = $urandom_range(4093, 2);
		for (int i = 0; i < LINE_DEPTH; i++) line_store[i] = '0;
		line_max_delay = MAX_DELAY_RESET;
		line_wptr      = span_of(line_max_delay) - 1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty line, overshoot to both rails, zero and end-of-line delays
		@(posedge clk);
		item_backlog.push_back(make_item(CMD_READ, 0, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, SMP_MIN, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, SMP_MAX, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, SMP_MAX, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, SMP_MIN, 0, 0));
		item_backlog.push_back(make_item(CMD_READ, 0, 1, 16'h8000));
		item_backlog.push_back(make_item(CMD_READ, 0, 0, 16'hFFFF));
		item_backlog.push_back(make_item(CMD_WRITE, SMP_MAX, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, SMP_MIN, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, SMP_MIN, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, SMP_MAX, 0, 0));
		item_backlog.push_back(make_item(CMD_READ, 0, 1, 16'h8000));
		item_backlog.push_back(make_item(CMD_READ, 0, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, 0, 4095, 16'hFFFF));
		item_backlog.push_back(make_item(CMD_WRITE, -1, 0, 0));
		item_backlog.push_back(make_item(CMD_WRITE, 1, 0, 0));
		item_backlog.push_back(make_item(CMD_READ, SMP_MIN, 2, 16'h4000));
		item_backlog.push_back(make_item(CMD_READ, SMP_MAX, 4095, 0));
		item_backlog.push_back(make_item(CMD_READ, 0, 4095, 1));
		item_backlog.push_back(make_item(CMD_READ, 0, 4095, 16'hFFFF));
		item_backlog.push_back(make_item(CMD_READ, 0, 4094, 16'hFFFF));
		item_backlog.push_back(make_item(CMD_READ, -1, 3, 16'hC000));
		queue_random(100, MAX_DELAY_RESET);

		for (int ph = 0; ph < 9; ph++) begin
			md = md_plan[ph];
			write_max_delay(md);
			@(posedge clk);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			if (ph == 4) begin
				// long hold-off on results while items keep coming, then a pause
				hold_req++;
				queue_random(80, md);
				wait_results_done();
				queue_random(70, md);
			end else begin
				queue_random(150, md);
			end
		end

		wait_results_done();
		repeat (40) @(posedge clk);
		$display("covered %0d write and %0d read transfers (%0d clamped)",
			writes_seen, reads_seen, clamps_seen);
		$display("over %0d max_delay settings and four idling patterns, %0d mismatches",
			settings_seen + 1, mismatch_count);
		if (mismatch_count == 0) begin
			$display("fractional_delay_line_hermite regression: pass");
		end else begin
			$display("fractional_delay_line_hermite regression: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", interp_due.size());
		$display("fractional_delay_line_hermite regression: fail");
		$finish;
	end

endmodule

[filelist.f]
rtl/fdlh_pkg.sv
rtl/fdlh_ram.sv
rtl/fdlh_datapath.sv
rtl/fdlh_ctrl.sv
rtl/fractional_delay_line_hermite.sv
tb/tb.sv
